// ===== hdl/qrub_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrub_pkg
// Shared constants, types and the per-grid-size geometry table for the
// QR module upscale blitter.
// ----------------------------------------------------------------------------
package qrub_pkg;

    localparam int CANVAS_WIDTH  = 128;
    localparam int CANVAS_HEIGHT = 64;
    localparam int QUIET_BORDER  = 1;

    localparam int ROW_BYTES   = (CANVAS_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * CANVAS_HEIGHT;

    localparam int AW   = $clog2(STORE_BYTES);
    localparam int XW   = $clog2(CANVAS_WIDTH);
    localparam int YW   = $clog2(CANVAS_HEIGHT);
    localparam int BW   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int SC_W = $clog2(CANVAS_HEIGHT + 1);
    localparam int CQ_W = 9;
    localparam int S_W  = 16;
    localparam int GRID_N = 256;

    localparam logic [7:0] PIX_MSB = 8'h80;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PAINT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_PLAN,
        ST_RD,
        ST_WR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [SC_W-1:0]       scale;
        logic signed [S_W-1:0] off_x;
        logic signed [S_W-1:0] off_y;
    } t_geom_ent;

    typedef t_geom_ent [GRID_N-1:0] t_geom_tab;

    // clipped block of one module, inclusive bounds
    typedef struct packed {
        logic          empty;
        logic [XW-1:0] xa;
        logic [XW-1:0] xl;
        logic [YW-1:0] ya;
        logic [YW-1:0] yl;
    } t_box;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic [AW-1:0] raddr;
    } t_ram_req;

    function automatic t_geom_tab build_geom_tab();
        t_geom_tab tab;
        int total;
        int sc;
        int span;
        for (int g = 0; g < GRID_N; g++) begin
            total = g + 2 * QUIET_BORDER;
            sc = 1;
            if (total > 0) begin
                for (int k = 1; k <= CANVAS_HEIGHT; k++) begin
                    if (k * total <= CANVAS_HEIGHT) begin
                        sc = k;
                    end
                end
            end
            span = total * sc;
            tab[g].scale = SC_W'(sc);
            tab[g].off_x = S_W'((CANVAS_WIDTH - span) / 2);
            tab[g].off_y = S_W'((CANVAS_HEIGHT - span) / 2);
        end
        return tab;
    endfunction

    localparam t_geom_tab GEOM_TAB = build_geom_tab();

endpackage

// ===== hdl/qr_module_upscale_blit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_module_upscale_blit
// Paints dark QR modules as scaled, centered, clipped blocks into a
// 1-bit packed canvas; also clears the canvas and reads back bytes.
// ----------------------------------------------------------------------------
//  channel   signals                                  dir  notes
//  command   start, busy, i_mode, i_module_col/row,   in   word taken on
//            i_module_dark, i_byte_addr                    start && !busy
//  result    o_strobe, o_pixel_byte,                  out  one-cycle strobe
//            o_pixel_byte_addr
//  config    i_cfg_we, i_cfg_wdata (grid_size)        in   write on i_cfg_we
//
//  Clear: busy while the 1024 canvas bytes are written, one byte per cycle.
//  Read: the strobe comes in the cycle after the accepting edge, set by the
//  registered read of the canvas RAM. Paint: busy through the states G1, G2,
//  G3 and PLAN of the geometry pipe, then a read and a write-back state per
//  canvas byte the block touches; a light or off-grid module leaves busy low.
//  Reset starts the same clear sweep, busy high throughout. The receiver
//  cannot stall; each result is shown once.
// ----------------------------------------------------------------------------
module qr_module_upscale_blit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_module_col,
    input  logic [7:0] i_module_row,
    input  logic       i_module_dark,
    input  logic [9:0] i_byte_addr,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_strobe,
    output logic [7:0] o_pixel_byte,
    output logic [9:0] o_pixel_byte_addr
);
    import qrub_pkg::*;

    logic [7:0] r_grid_size;
    logic [7:0] col;
    logic [7:0] row;
    t_box       box;
    t_ram_req   req;
    logic [7:0] rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= 8'd21;
        end else if (i_cfg_we) begin
            r_grid_size <= i_cfg_wdata;
        end
    end

    qrub_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_mode            (i_mode),
        .i_module_col      (i_module_col),
        .i_module_row      (i_module_row),
        .i_module_dark     (i_module_dark),
        .i_byte_addr       (i_byte_addr),
        .i_grid_size       (r_grid_size),
        .o_col             (col),
        .o_row             (row),
        .i_box             (box),
        .o_req             (req),
        .i_rdata           (rdata),
        .o_strobe          (o_strobe),
        .o_pixel_byte      (o_pixel_byte),
        .o_pixel_byte_addr (o_pixel_byte_addr)
    );

    qrub_geom u_geom (
        .i_clk       (i_clk),
        .i_grid_size (r_grid_size),
        .i_col       (col),
        .i_row       (row),
        .o_box       (box)
    );

    qrub_canvas u_canvas (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

`ifndef SYNTHESIS
    a_strobe_after_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && (i_mode == MODE_READ)))
        else $error("result strobe without a read command");

    a_addr_echo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_pixel_byte_addr == $past(i_byte_addr)))
        else $error("echoed address mismatch");

    a_read_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_READ)) |=> o_strobe)
        else $error("read command gave no result");

    a_clear_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_CLEAR)) |=> (busy && !o_strobe))
        else $error("clear command did not start the sweep");
`endif

endmodule

// ===== hdl/qrub_canvas.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrub_canvas
// Canvas byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qrub_canvas (
    input  logic              i_clk,
    input  qrub_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);
    import qrub_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// ===== hdl/qrub_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrub_geom
// Three-stage geometry pipe: scale/offset lookup, block origin, clipping.
// ----------------------------------------------------------------------------
module qrub_geom (
    input  logic             i_clk,
    input  logic [7:0]       i_grid_size,
    input  logic [7:0]       i_col,
    input  logic [7:0]       i_row,
    output qrub_pkg::t_box   o_box
);
    import qrub_pkg::*;

    t_geom_ent             r_ent;
    logic [CQ_W-1:0]       r_colq;
    logic [CQ_W-1:0]       r_rowq;
    logic signed [S_W-1:0] r_x0;
    logic signed [S_W-1:0] r_y0;
    logic [SC_W-1:0]       r_scale;

    logic [CQ_W+SC_W-1:0]  px;
    logic [CQ_W+SC_W-1:0]  py;
    logic signed [S_W-1:0] xe;
    logic signed [S_W-1:0] ye;
    logic signed [S_W-1:0] xa_s;
    logic signed [S_W-1:0] xb_s;
    logic signed [S_W-1:0] ya_s;
    logic signed [S_W-1:0] yb_s;
    t_box                  n_box;

    always_ff @(posedge i_clk) begin
        r_ent  <= GEOM_TAB[i_grid_size];
        r_colq <= CQ_W'(i_col) + CQ_W'(QUIET_BORDER);
        r_rowq <= CQ_W'(i_row) + CQ_W'(QUIET_BORDER);
    end

    assign px = (CQ_W+SC_W)'(r_colq) * (CQ_W+SC_W)'(r_ent.scale);
    assign py = (CQ_W+SC_W)'(r_rowq) * (CQ_W+SC_W)'(r_ent.scale);

    always_ff @(posedge i_clk) begin
        r_x0    <= r_ent.off_x + $signed(S_W'(px));
        r_y0    <= r_ent.off_y + $signed(S_W'(py));
        r_scale <= r_ent.scale;
    end

    always_comb begin
        xe   = r_x0 + $signed(S_W'(r_scale));
        ye   = r_y0 + $signed(S_W'(r_scale));
        xa_s = (r_x0 < 0) ? '0 : r_x0;
        ya_s = (r_y0 < 0) ? '0 : r_y0;
        xb_s = (xe > S_W'(CANVAS_WIDTH))  ? S_W'(CANVAS_WIDTH)  : xe;
        yb_s = (ye > S_W'(CANVAS_HEIGHT)) ? S_W'(CANVAS_HEIGHT) : ye;
        n_box.empty = (xa_s >= xb_s) || (ya_s >= yb_s);
        n_box.xa    = XW'(xa_s);
        n_box.xl    = XW'(xb_s - S_W'(1));
        n_box.ya    = YW'(ya_s);
        n_box.yl    = YW'(yb_s - S_W'(1));
    end

    always_ff @(posedge i_clk) begin
        o_box <= n_box;
    end

endmodule

// ===== hdl/qrub_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrub_ctrl
// Command sequencer: clear sweep, per-byte read-modify-write painting and
// byte readback.
// ----------------------------------------------------------------------------
module qrub_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_module_col,
    input  logic [7:0]         i_module_row,
    input  logic               i_module_dark,
    input  logic [9:0]         i_byte_addr,
    input  logic [7:0]         i_grid_size,
    output logic [7:0]         o_col,
    output logic [7:0]         o_row,
    input  qrub_pkg::t_box     i_box,
    output qrub_pkg::t_ram_req o_req,
    input  logic [7:0]         i_rdata,
    output logic               o_strobe,
    output logic [7:0]         o_pixel_byte,
    output logic [9:0]         o_pixel_byte_addr
);
    import qrub_pkg::*;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [YW-1:0] r_y, n_y;
    logic [BW-1:0] r_b, n_b;
    logic [7:0]    r_col, n_col;
    logic [7:0]    r_row, n_row;
    logic [9:0]    r_out_addr, n_out_addr;
    logic          r_out_ok, n_out_ok;

    logic          accept;
    logic [BW-1:0] b_first;
    logic [BW-1:0] b_last;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;
    logic [AW-1:0] paint_addr;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign b_first = BW'(i_box.xa >> 3);
    assign b_last  = BW'(i_box.xl >> 3);
    assign paint_addr = AW'(AW'(r_y) * AW'(ROW_BYTES) + AW'(r_b));

    always_comb begin
        lo   = (r_b == b_first) ? i_box.xa[2:0] : 3'd0;
        hi   = (r_b == b_last)  ? i_box.xl[2:0] : 3'd7;
        mask = '0;
        for (int p = 0; p < 8; p++) begin
            if ((3'(p) >= lo) && (3'(p) <= hi)) begin
                mask = mask | (PIX_MSB >> p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y        <= n_y;
        r_b        <= n_b;
        r_col      <= n_col;
        r_row      <= n_row;
        r_out_addr <= n_out_addr;
        r_out_ok   <= n_out_ok;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_y        = r_y;
        n_b        = r_b;
        n_col      = r_col;
        n_row      = r_row;
        n_out_addr = r_out_addr;
        n_out_ok   = r_out_ok;
        o_req.we    = 1'b0;
        o_req.waddr = paint_addr;
        o_req.wdata = i_rdata | mask;
        o_req.raddr = paint_addr;
        o_strobe    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req.raddr = AW'(i_byte_addr);
                if (accept) begin
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        MODE_PAINT: begin
                            n_col = i_module_col;
                            n_row = i_module_row;
                            if (i_module_dark && (i_module_col < i_grid_size)
                                    && (i_module_row < i_grid_size)) begin
                                n_state = ST_G1;
                            end
                        end
                        MODE_READ: begin
                            n_out_addr = i_byte_addr;
                            n_out_ok   = ({1'b0, i_byte_addr} < 11'(STORE_BYTES));
                            n_state    = ST_RESP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_clr;
                o_req.wdata = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_G1: n_state = ST_G2;
            ST_G2: n_state = ST_G3;
            ST_G3: n_state = ST_PLAN;
            ST_PLAN: begin
                n_y = i_box.ya;
                n_b = b_first;
                n_state = i_box.empty ? ST_IDLE : ST_RD;
            end
            ST_RD: n_state = ST_WR;
            ST_WR: begin
                o_req.we = 1'b1;
                n_state  = ST_RD;
                if (r_b == b_last) begin
                    n_b = b_first;
                    if (r_y == i_box.yl) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_y = r_y + YW'(1);
                    end
                end else begin
                    n_b = r_b + BW'(1);
                end
            end
            ST_RESP: begin
                o_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_col             = r_col;
    assign o_row             = r_row;
    assign o_pixel_byte      = r_out_ok ? i_rdata : 8'd0;
    assign o_pixel_byte_addr = r_out_addr;

endmodule
